// File: sv/trigger_threshold_prescale_fsm_assert.svh
// Assertion macros used by the threshold trigger top-level file.
`ifndef TRIGGER_THRESHOLD_PRESCALE_FSM_ASSERT_SVH
`define TRIGGER_THRESHOLD_PRESCALE_FSM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTPF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("threshold trigger check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("threshold trigger check failed");

`endif

// File: sv/ttpf_pkg.sv
package ttpf_pkg;

    localparam int STEPS_PER_SAMPLE_DEF = 19;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};

    localparam logic [15:0] PRESCALE_RST  = 16'd0;
    localparam logic [15:0] THRESHOLD_RST = 16'd100;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

    typedef logic [2:0] state_t;

    localparam state_t ST_DIS = 3'd0;
    localparam state_t ST_RUN = 3'd1;
    localparam state_t ST_EXC = 3'd2;
    localparam state_t ST_PRE = 3'd3;
    localparam state_t ST_ACT = 3'd4;
    localparam state_t ST_WAI = 3'd5;

    // Machine state carried from sample to sample.
    typedef struct packed {
        state_t           fsm;
        logic [CNT_W-1:0] count;
    } mach_t;

    // Per-sample decisions, fixed for all steps of one sample.
    typedef struct packed {
        logic hi;   // higher priority trigger active
        logic ten;  // trigger enable
        logic thr;  // sum enabled, trigger enabled and sum at or above threshold
        logic rel;  // sum enabled and hysteresis sum below threshold
    } cond_t;

    typedef struct packed {
        logic exc;
        logic act;
    } flags_t;

    function automatic logic [CNT_W-1:0] cnt_sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = (c == CNT_MAX) ? c : c + {{(CNT_W-1){1'b0}}, 1'b1};
        return r;
    endfunction

endpackage

// File: sv/ttpf_step.sv
// One step of the threshold machine, with the flags of that step.
module ttpf_step (
    input  ttpf_pkg::cond_t                 cond,
    input  ttpf_pkg::mach_t                 mach_in,
    input  logic [ttpf_pkg::CNT_W-1:0]      prescale,
    output ttpf_pkg::mach_t                 mach_out,
    output ttpf_pkg::flags_t                flags
);

    always_comb begin
        mach_out = mach_in;
        flags    = '0;
        case (mach_in.fsm)
            ttpf_pkg::ST_DIS: begin
                mach_out.fsm = ttpf_pkg::ST_RUN;
            end
            ttpf_pkg::ST_RUN: begin
                if (cond.thr) begin
                    flags.exc    = 1'b1;
                    mach_out.fsm = ttpf_pkg::ST_EXC;
                end
            end
            ttpf_pkg::ST_EXC: begin
                flags.exc = 1'b1;
                if (cond.hi) begin
                    mach_out.fsm = ttpf_pkg::ST_WAI;
                end else if (mach_in.count == '0) begin
                    flags.act      = 1'b1;
                    mach_out.count = prescale;
                    mach_out.fsm   = ttpf_pkg::ST_ACT;
                end else begin
                    mach_out.count = mach_in.count - ttpf_pkg::CNT_ONE;
                    mach_out.fsm   = ttpf_pkg::ST_PRE;
                end
            end
            ttpf_pkg::ST_PRE: begin
                if (cond.rel) begin
                    mach_out.fsm = ttpf_pkg::ST_RUN;
                end else if (cond.hi) begin
                    flags.exc      = 1'b1;
                    mach_out.count = ttpf_pkg::cnt_sat_inc(mach_in.count);
                    mach_out.fsm   = ttpf_pkg::ST_WAI;
                end else begin
                    flags.exc = 1'b1;
                end
            end
            ttpf_pkg::ST_ACT: begin
                flags.exc = 1'b1;
                if (!cond.ten) begin
                    mach_out.fsm = ttpf_pkg::ST_WAI;
                end else begin
                    flags.act = 1'b1;
                end
            end
            ttpf_pkg::ST_WAI: begin
                if (cond.rel) begin
                    mach_out.fsm = ttpf_pkg::ST_RUN;
                end else begin
                    flags.exc = 1'b1;
                end
            end
            default: begin
                mach_out.fsm = ttpf_pkg::ST_DIS;
            end
        endcase
    end

endmodule

// File: sv/ttpf_advance.sv
// Closed-form advance of the machine over all but the last step of a sample.
// Every start state reaches either a fixed point or the running state within
// three steps; from running, the run/exceeded/prescaled loop has period three,
// so the step count splits into a quotient and a phase known at elaboration.
module ttpf_advance #(
    parameter int STEPS_PER_SAMPLE = ttpf_pkg::STEPS_PER_SAMPLE_DEF
) (
    input  ttpf_pkg::cond_t                 cond,
    input  ttpf_pkg::mach_t                 mach_in,
    input  logic [ttpf_pkg::CNT_W-1:0]      prescale,
    output ttpf_pkg::mach_t                 mach_out
);

    localparam int K   = STEPS_PER_SAMPLE - 1;
    localparam int KD1 = (K >= 1) ? K - 1 : 0;
    localparam int KD2 = (K >= 2) ? K - 2 : 0;
    localparam int KD3 = (K >= 3) ? K - 3 : 0;
    localparam int Q0 = K / 3;
    localparam int Q1 = KD1 / 3;
    localparam int Q2 = KD2 / 3;
    localparam int Q3 = KD3 / 3;
    localparam int R0 = K % 3;
    localparam int R1 = KD1 % 3;
    localparam int R2 = KD2 % 3;
    localparam int R3 = KD3 % 3;

    logic                          use_run;
    logic [1:0]                    ofs;
    logic [ttpf_pkg::CNT_W-1:0]    run_cnt;
    ttpf_pkg::mach_t               direct;
    logic [ttpf_pkg::CNT_W-1:0]    q_sel;
    logic [1:0]                    r_sel;
    logic                          kz_sel;
    logic                          k1_sel;
    ttpf_pkg::mach_t               from_run;

    // Steps until the running state is entered, or the final state if it never is.
    always_comb begin
        use_run = 1'b0;
        ofs     = 2'd0;
        run_cnt = mach_in.count;
        direct  = mach_in;
        if (K != 0) begin
            case (mach_in.fsm)
                ttpf_pkg::ST_DIS: begin
                    use_run = 1'b1;
                    ofs     = 2'd1;
                end
                ttpf_pkg::ST_RUN: begin
                    use_run = 1'b1;
                end
                ttpf_pkg::ST_WAI: begin
                    use_run = cond.rel;
                    ofs     = 2'd1;
                end
                ttpf_pkg::ST_ACT: begin
                    if (!cond.ten) begin
                        direct.fsm = ttpf_pkg::ST_WAI;
                        if (K >= 2) begin
                            use_run = cond.rel;
                            ofs     = 2'd2;
                        end
                    end
                end
                ttpf_pkg::ST_PRE: begin
                    if (cond.rel) begin
                        use_run = 1'b1;
                        ofs     = 2'd1;
                    end else if (cond.hi) begin
                        direct.fsm   = ttpf_pkg::ST_WAI;
                        direct.count = ttpf_pkg::cnt_sat_inc(mach_in.count);
                    end
                end
                ttpf_pkg::ST_EXC: begin
                    if (cond.hi) begin
                        direct.fsm = ttpf_pkg::ST_WAI;
                        if (K >= 2) begin
                            use_run = cond.rel;
                            ofs     = 2'd2;
                        end
                    end else if (mach_in.count == '0) begin
                        // Reload, then hold active while enabled.
                        direct.fsm   = ttpf_pkg::ST_ACT;
                        direct.count = prescale;
                        run_cnt      = prescale;
                        if (!cond.ten && K >= 2) begin
                            direct.fsm = ttpf_pkg::ST_WAI;
                            if (K >= 3) begin
                                use_run = cond.rel;
                                ofs     = 2'd3;
                            end
                        end
                    end else begin
                        direct.fsm   = ttpf_pkg::ST_PRE;
                        direct.count = mach_in.count - ttpf_pkg::CNT_ONE;
                        run_cnt      = mach_in.count - ttpf_pkg::CNT_ONE;
                        if (K >= 2) begin
                            use_run = cond.rel;
                            ofs     = 2'd2;
                        end
                    end
                end
                default: begin
                    direct.fsm = ttpf_pkg::ST_DIS;
                    if (K >= 2) begin
                        use_run = 1'b1;
                        ofs     = 2'd2;
                    end
                end
            endcase
        end
    end

    // Remaining step count from the running state, as quotient and phase.
    always_comb begin
        case (ofs)
            2'd0: begin
                q_sel  = ttpf_pkg::CNT_W'(Q0);
                r_sel  = 2'(R0);
                kz_sel = (K == 0);
                k1_sel = (K == 1);
            end
            2'd1: begin
                q_sel  = ttpf_pkg::CNT_W'(Q1);
                r_sel  = 2'(R1);
                kz_sel = (KD1 == 0);
                k1_sel = (KD1 == 1);
            end
            2'd2: begin
                q_sel  = ttpf_pkg::CNT_W'(Q2);
                r_sel  = 2'(R2);
                kz_sel = (KD2 == 0);
                k1_sel = (KD2 == 1);
            end
            default: begin
                q_sel  = ttpf_pkg::CNT_W'(Q3);
                r_sel  = 2'(R3);
                kz_sel = (KD3 == 0);
                k1_sel = (KD3 == 1);
            end
        endcase
    end

    // Position after the remaining steps, starting in the running state.
    always_comb begin
        from_run.fsm   = ttpf_pkg::ST_RUN;
        from_run.count = run_cnt;
        if (cond.thr) begin
            if (cond.hi) begin
                if (cond.rel) begin
                    case (r_sel)
                        2'd0:    from_run.fsm = ttpf_pkg::ST_RUN;
                        2'd1:    from_run.fsm = ttpf_pkg::ST_EXC;
                        default: from_run.fsm = ttpf_pkg::ST_WAI;
                    endcase
                end else if (kz_sel) begin
                    from_run.fsm = ttpf_pkg::ST_RUN;
                end else if (k1_sel) begin
                    from_run.fsm = ttpf_pkg::ST_EXC;
                end else begin
                    from_run.fsm = ttpf_pkg::ST_WAI;
                end
            end else if (cond.rel) begin
                // Each pass of the loop takes one off the count until it is spent.
                if (q_sel < run_cnt || (q_sel == run_cnt && r_sel != 2'd2)) begin
                    case (r_sel)
                        2'd0: begin
                            from_run.fsm   = ttpf_pkg::ST_RUN;
                            from_run.count = run_cnt - q_sel;
                        end
                        2'd1: begin
                            from_run.fsm   = ttpf_pkg::ST_EXC;
                            from_run.count = run_cnt - q_sel;
                        end
                        default: begin
                            from_run.fsm   = ttpf_pkg::ST_PRE;
                            from_run.count = run_cnt - q_sel - ttpf_pkg::CNT_ONE;
                        end
                    endcase
                end else begin
                    from_run.fsm   = ttpf_pkg::ST_ACT;
                    from_run.count = prescale;
                end
            end else if (kz_sel) begin
                from_run.fsm = ttpf_pkg::ST_RUN;
            end else if (k1_sel) begin
                from_run.fsm = ttpf_pkg::ST_EXC;
            end else if (run_cnt == '0) begin
                from_run.fsm   = ttpf_pkg::ST_ACT;
                from_run.count = prescale;
            end else begin
                from_run.fsm   = ttpf_pkg::ST_PRE;
                from_run.count = run_cnt - ttpf_pkg::CNT_ONE;
            end
        end
    end

    assign mach_out = use_run ? from_run : direct;

endmodule

// File: sv/trigger_threshold_prescale_fsm.sv
// A sample is registered in the input stage, then its result in the output stage.
// Throughput: one sample per clock while the output is not stalled; all steps of a
// sample are evaluated together in the combinational state and prescale count update.
// Reset: synchronous, active low; clears both stages, puts the machine in the
// disabled state with a zero count, prescale to 0 and threshold to 100.
module trigger_threshold_prescale_fsm #(
    parameter int STEPS_PER_SAMPLE = ttpf_pkg::STEPS_PER_SAMPLE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [ttpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_wdata,

    // Sample input. tdata from bit 0: higher_active, trigger_enable,
    // sum_enable, hysteresis_sum[15:0], signal_sum[15:0], zero fill.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,

    // Result output. tdata from bit 0: pass_on, fire_active, zero fill.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata
);

    `include "trigger_threshold_prescale_fsm_assert.svh"

    // Configuration registers.
    logic [15:0] prescale_reg;
    logic [15:0] threshold_reg;

    // Input stage: the comparisons against the threshold are taken at the transfer, so
    // the user must change the threshold only while the block is idle; it is not enforced.
    logic             in_valid_reg;
    ttpf_pkg::cond_t  cond_reg;
    ttpf_pkg::cond_t  cond_next;

    // Machine state that carries from one sample to the next.
    ttpf_pkg::mach_t  mach_reg;
    ttpf_pkg::mach_t  mach_next;
    ttpf_pkg::mach_t  mach_last;

    // Output stage.
    logic             out_valid_reg;
    ttpf_pkg::flags_t flags_next;
    logic             pass_on_reg;
    logic             fire_active_reg;

    logic             advance;
    logic             s_xfer;

    // A sample moves to the output stage whenever that stage is empty or being
    // drained; the input side stalls only while it is full and a result waits.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        cond_next.hi  = s_tdata[0];
        cond_next.ten = s_tdata[1];
        cond_next.thr = s_tdata[1] && s_tdata[2] && (s_tdata[34:19] >= threshold_reg);
        cond_next.rel = s_tdata[2] && (s_tdata[18:3] < threshold_reg);
    end

    // All steps but the last are folded into one closed-form advance; the
    // last step is evaluated explicitly because it also yields the flags.
    ttpf_advance #(
        .STEPS_PER_SAMPLE (STEPS_PER_SAMPLE)
    ) u_advance (
        .cond     (cond_reg),
        .mach_in  (mach_reg),
        .prescale (prescale_reg),
        .mach_out (mach_last)
    );

    ttpf_step u_step (
        .cond     (cond_reg),
        .mach_in  (mach_last),
        .prescale (prescale_reg),
        .mach_out (mach_next),
        .flags    (flags_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg   <= ttpf_pkg::PRESCALE_RST;
            threshold_reg  <= ttpf_pkg::THRESHOLD_RST;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mach_reg.fsm   <= ttpf_pkg::ST_DIS;
            mach_reg.count <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    ttpf_pkg::CFG_PRESCALE:  prescale_reg  <= cfg_wdata;
                    ttpf_pkg::CFG_THRESHOLD: threshold_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                mach_reg      <= mach_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cond_reg <= cond_next;
        end
        if (advance) begin
            pass_on_reg     <= flags_next.exc || cond_reg.hi;
            fire_active_reg <= flags_next.act;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, fire_active_reg, pass_on_reg};

    // A sample taken from the input stage always shows up as a result.
    `TTPF_ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, advance, out_valid_reg)
    // A sample that cannot move on is kept, not dropped.
    `TTPF_ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)
    // The machine state only moves when a sample is processed.
    `TTPF_ASSERT_NEXT(a_state_stable, aclk, aresetn, !advance, $stable(mach_reg))
    // An active threshold is always exceeded, so it always passes on.
    `TTPF_ASSERT_SAME(a_active_passes, aclk, aresetn, m_tvalid && m_tdata[1], m_tdata[0])
    // With the output stage empty, the input side never stalls.
    `TTPF_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_tready)

endmodule
